FILE: src/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared constants for the breakpoint table and next-PC predictor: host
// command codes, result status codes, configuration register indexes and
// the instruction classes that the predictor decodes.
// ----------------------------------------------------------------------------
package bpt_pkg;

	// Host commands
	localparam logic [2:0] CMD_CLEAR     = 3'd0;
	localparam logic [2:0] CMD_SET       = 3'd1;
	localparam logic [2:0] CMD_REMOVE    = 3'd2;
	localparam logic [2:0] CMD_STEP_INTO = 3'd3;
	localparam logic [2:0] CMD_STEP_OVER = 3'd4;
	localparam logic [2:0] CMD_CONTINUE  = 3'd5;
	localparam logic [2:0] CMD_WRITE_REG = 3'd6;

	// Result status
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ALREADY   = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_ROM       = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_REG_ZERO  = 3'd5;
	localparam logic [2:0] ST_LOOP_BACK = 3'd6;

	// Configuration registers
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_START  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BREAK_WORD = 1'd1;
	localparam logic [20:0] ROM_START_RST  = 21'h80000;
	localparam logic [31:0] BREAK_WORD_RST = 32'h0;

	// Instruction classes (top nibble of the word)
	localparam logic [3:0] OP_J    = 4'h4;
	localparam logic [3:0] OP_JR   = 4'h5;
	localparam logic [3:0] OP_JAL  = 4'h6;
	localparam logic [3:0] OP_JALR = 4'h7;
	localparam logic [3:0] OP_BEQZ = 4'ha;
	localparam logic [3:0] OP_BNEZ = 4'hb;

	// Link register written on a jump-and-link that loops onto itself
	localparam logic [3:0] LINK_REG = 4'd15;

endpackage

FILE: src/bpt_predict.sv
// ----------------------------------------------------------------------------
// bpt_predict
// Next-PC prediction for one instruction: absolute jumps, register jumps
// and compare-with-zero branches with a sign-extended 20-bit offset.
// ----------------------------------------------------------------------------
module bpt_predict (
	input  logic [19:0] pc,
	input  logic [31:0] insn,
	input  logic        into,
	input  logic [31:0] rs,
	output logic [31:0] next_pc
);

	logic [3:0]  op;
	logic [31:0] seq_pc;
	logic [31:0] off;
	logic [31:0] br_pc;

	assign op     = insn[31:28];
	assign seq_pc = {12'b0, pc} + 32'd1;
	assign off    = {{12{insn[19]}}, insn[19:0]};
	assign br_pc  = seq_pc + off;

	// Link forms are followed only when stepping into
	always_comb begin
		next_pc = seq_pc;
		case (op) inside
			bpt_pkg::OP_J, bpt_pkg::OP_JAL: begin
				if (into || op == bpt_pkg::OP_J) next_pc = {12'b0, insn[19:0]};
			end
			bpt_pkg::OP_JR, bpt_pkg::OP_JALR: begin
				if (into || op == bpt_pkg::OP_JR) next_pc = rs;
			end
			bpt_pkg::OP_BEQZ: begin
				if (rs == 32'd0) next_pc = br_pc;
			end
			bpt_pkg::OP_BNEZ: begin
				if (rs != 32'd0) next_pc = br_pc;
			end
			default: next_pc = seq_pc;
		endcase
	end

endmodule

FILE: src/breakpoint_table_step_target_unit.sv
// ----------------------------------------------------------------------------
// breakpoint_table_step_target_unit
// Software-breakpoint table with register shadow and single-step next-PC
// prediction. One host command in, one result beat out.
// ----------------------------------------------------------------------------
// One command is handled at a time. Clear, write-register and undefined
// commands go straight to the result stage. Set and remove scan the table
// one entry per cycle through its synchronous read port; set stops at the
// first matching or free entry, remove at the first match. Step and continue
// on a break word scan the same way, without one they skip the scan; steps
// then do the register-shadow read and the prediction, continue only on a
// match (else it just starts the run). The result sits in an output register,
// so the next command is taken while an earlier result waits. No clearing
// pass follows reset: valid bits in flip-flops cover both stores.
// ----------------------------------------------------------------------------
module breakpoint_table_step_target_unit #(
	parameter int unsigned TABLE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [19:0] address,
	input  logic [31:0] mem_word,
	input  logic [3:0]  reg_index,
	input  logic [31:0] reg_value,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] target_addr,
	output logic        plant_valid,
	output logic        restore_valid,
	output logic [31:0] restore_word,
	output logic        start_run,
	output logic        on_breakpoint,
	// configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);

	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_REG_RD, S_EXEC, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [20:0] rom_start_q;
	logic [31:0] break_word_q;

	// latched command
	logic [2:0]  op_q;
	logic [19:0] addr_q;
	logic [31:0] word_q;
	logic [31:0] insn_q;
	logic        hit_q;

	// working result
	logic [2:0]  status_q;
	logic [31:0] target_q;
	logic        plant_q;
	logic        restore_q;
	logic [31:0] rword_q;
	logic        run_q;
	logic        onbp_q;

	// output register
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [31:0] out_target_q;
	logic        out_plant_q;
	logic        out_restore_q;
	logic [31:0] out_rword_q;
	logic        out_run_q;
	logic        out_onbp_q;

	// table: valid bits in flops, address and instruction in memories
	logic [TABLE_DEPTH-1:0] ev_q;
	logic [19:0] ea_mem [TABLE_DEPTH];
	logic [31:0] ei_mem [TABLE_DEPTH];
	logic [19:0] ea_rd_s1;
	logic [31:0] ei_rd_s1;

	// scan pipeline
	logic [IW-1:0] idx_q;
	logic          issue_q;
	logic          cmp_vld_s1;
	logic [IW-1:0] cmp_idx_s1;

	// register shadow
	logic [15:0] rv_q;
	logic [31:0] rs_mem [16];
	logic [31:0] rs_rd_s1;

	// combinational
	logic        in_fire;
	logic        cmp_match;
	logic        cmp_free;
	logic        cmp_last;
	logic        set_in_rom;
	logic        ent_we;
	logic        reg_we;
	logic [3:0]  reg_widx;
	logic [31:0] reg_wdata;
	logic [31:0] rs_val;
	logic [31:0] pred_pc;
	logic        loop_back;
	logic        tgt_in_rom;
	logic        is_link;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Scan compare on the entry read last cycle
	assign cmp_match  = ev_q[cmp_idx_s1] && (ea_rd_s1 == addr_q);
	assign cmp_free   = !ev_q[cmp_idx_s1];
	assign cmp_last   = (cmp_idx_s1 == LAST_IDX);
	assign set_in_rom = ({1'b0, addr_q} >= rom_start_q);

	assign ent_we = (state_q == S_SCAN) && cmp_vld_s1 && (op_q == bpt_pkg::CMD_SET) &&
	                !cmp_match && cmp_free && !set_in_rom;

	// Prediction
	assign rs_val     = rv_q[insn_q[23:20]] ? rs_rd_s1 : 32'd0;
	assign loop_back  = (pred_pc == {12'b0, addr_q});
	assign tgt_in_rom = (pred_pc >= {11'b0, rom_start_q});
	assign is_link    = (insn_q[31:28] == bpt_pkg::OP_JAL) ||
	                    (insn_q[31:28] == bpt_pkg::OP_JALR);

	bpt_predict u_predict (
		.pc      (addr_q),
		.insn    (insn_q),
		.into    (op_q != bpt_pkg::CMD_STEP_OVER),
		.rs      (rs_val),
		.next_pc (pred_pc)
	);

	// Shadow write: host write on accept, link write when a jump-and-link loops back
	always_comb begin
		reg_we    = 1'b0;
		reg_widx  = reg_index;
		reg_wdata = reg_value;
		if (in_fire && opcode == bpt_pkg::CMD_WRITE_REG && reg_index != 4'd0) begin
			reg_we = 1'b1;
		end else if (state_q == S_EXEC && loop_back && is_link) begin
			reg_we    = 1'b1;
			reg_widx  = bpt_pkg::LINK_REG;
			reg_wdata = {12'b0, addr_q} + 32'd1;
		end
	end

	// Table memories
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ea_mem[cmp_idx_s1] <= addr_q;
			ei_mem[cmp_idx_s1] <= word_q;
		end
		ea_rd_s1 <= ea_mem[idx_q];
		ei_rd_s1 <= ei_mem[idx_q];
	end

	// Register shadow memory
	always_ff @(posedge clk) begin
		if (reg_we) rs_mem[reg_widx] <= reg_wdata;
		rs_rd_s1 <= rs_mem[insn_q[23:20]];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_start_q  <= bpt_pkg::ROM_START_RST;
			break_word_q <= bpt_pkg::BREAK_WORD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bpt_pkg::CFG_ROM_START:  rom_start_q  <= cfg_data[20:0];
				bpt_pkg::CFG_BREAK_WORD: break_word_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Command sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ev_q          <= '0;
			rv_q          <= '0;
			issue_q       <= 1'b0;
			cmp_vld_s1    <= 1'b0;
			idx_q         <= '0;
			cmp_idx_s1    <= '0;
			out_valid_q   <= 1'b0;
			op_q          <= '0;
			addr_q        <= '0;
			word_q        <= '0;
			insn_q        <= '0;
			hit_q         <= 1'b0;
			status_q      <= '0;
			target_q      <= '0;
			plant_q       <= 1'b0;
			restore_q     <= 1'b0;
			rword_q       <= '0;
			run_q         <= 1'b0;
			onbp_q        <= 1'b0;
			out_status_q  <= '0;
			out_target_q  <= '0;
			out_plant_q   <= 1'b0;
			out_restore_q <= 1'b0;
			out_rword_q   <= '0;
			out_run_q     <= 1'b0;
			out_onbp_q    <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (reg_we) rv_q[reg_widx] <= 1'b1;

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						op_q      <= opcode;
						addr_q    <= address;
						word_q    <= mem_word;
						insn_q    <= mem_word;
						hit_q     <= 1'b0;
						status_q  <= bpt_pkg::ST_OK;
						target_q  <= '0;
						plant_q   <= 1'b0;
						restore_q <= 1'b0;
						rword_q   <= '0;
						run_q     <= 1'b0;
						onbp_q    <= 1'b0;
						idx_q      <= '0;
						issue_q    <= 1'b1;
						cmp_vld_s1 <= 1'b0;
						unique case (opcode) inside
							bpt_pkg::CMD_CLEAR: begin
								ev_q    <= '0;
								state_q <= S_OUT;
							end
							bpt_pkg::CMD_SET, bpt_pkg::CMD_REMOVE: begin
								target_q <= {12'b0, address};
								state_q  <= S_SCAN;
							end
							bpt_pkg::CMD_STEP_INTO, bpt_pkg::CMD_STEP_OVER,
							bpt_pkg::CMD_CONTINUE: begin
								if (mem_word == break_word_q) begin
									state_q <= S_SCAN;
								end else if (opcode == bpt_pkg::CMD_CONTINUE) begin
									run_q   <= 1'b1;
									state_q <= S_OUT;
								end else begin
									state_q <= S_REG_RD;
								end
							end
							bpt_pkg::CMD_WRITE_REG: begin
								if (reg_index == 4'd0) status_q <= bpt_pkg::ST_REG_ZERO;
								state_q <= S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end

				S_SCAN: begin
					// issue one entry read a cycle, compare the one read before
					if (issue_q) begin
						if (idx_q == LAST_IDX) issue_q <= 1'b0;
						else idx_q <= idx_q + IW'(1);
					end
					cmp_vld_s1 <= issue_q;
					cmp_idx_s1 <= idx_q;
					if (cmp_vld_s1) begin
						case (op_q)
							bpt_pkg::CMD_SET: begin
								if (cmp_match) begin
									status_q <= bpt_pkg::ST_ALREADY;
									state_q  <= S_OUT;
								end else if (cmp_free) begin
									if (set_in_rom) begin
										status_q <= bpt_pkg::ST_ROM;
									end else begin
										ev_q[cmp_idx_s1] <= 1'b1;
										plant_q          <= 1'b1;
										status_q         <= bpt_pkg::ST_OK;
									end
									state_q <= S_OUT;
								end else if (cmp_last) begin
									status_q <= bpt_pkg::ST_FULL;
									state_q  <= S_OUT;
								end
							end
							bpt_pkg::CMD_REMOVE: begin
								if (cmp_match) begin
									ev_q[cmp_idx_s1] <= 1'b0;
									restore_q        <= 1'b1;
									rword_q          <= ei_rd_s1;
									status_q         <= bpt_pkg::ST_OK;
									state_q          <= S_OUT;
								end else if (cmp_last) begin
									status_q <= bpt_pkg::ST_NOT_FOUND;
									state_q  <= S_OUT;
								end
							end
							default: begin
								// step or continue looking for the recorded original
								if (cmp_match) begin
									hit_q   <= 1'b1;
									onbp_q  <= 1'b1;
									insn_q  <= ei_rd_s1;
									state_q <= S_REG_RD;
								end else if (cmp_last) begin
									if (op_q == bpt_pkg::CMD_CONTINUE) begin
										run_q   <= 1'b1;
										state_q <= S_OUT;
									end else begin
										state_q <= S_REG_RD;
									end
								end
							end
						endcase
					end
				end

				S_REG_RD: begin
					// shadow read of the source register is in flight
					state_q <= S_EXEC;
				end

				S_EXEC: begin
					target_q <= pred_pc;
					if (loop_back) begin
						status_q <= bpt_pkg::ST_LOOP_BACK;
						run_q    <= (op_q == bpt_pkg::CMD_CONTINUE);
					end else begin
						if (op_q != bpt_pkg::CMD_CONTINUE && hit_q) begin
							restore_q <= 1'b1;
							rword_q   <= insn_q;
						end
						if (tgt_in_rom) begin
							status_q <= bpt_pkg::ST_ROM;
						end else begin
							if (op_q == bpt_pkg::CMD_CONTINUE) begin
								restore_q <= 1'b1;
								rword_q   <= insn_q;
							end
							plant_q <= 1'b1;
							run_q   <= 1'b1;
						end
					end
					state_q <= S_OUT;
				end

				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= status_q;
						out_target_q  <= target_q;
						out_plant_q   <= plant_q;
						out_restore_q <= restore_q;
						out_rword_q   <= rword_q;
						out_run_q     <= run_q;
						out_onbp_q    <= onbp_q;
						state_q       <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign target_addr   = out_target_q;
	assign plant_valid   = out_plant_q;
	assign restore_valid = out_restore_q;
	assign restore_word  = out_rword_q;
	assign start_run     = out_run_q;
	assign on_breakpoint = out_onbp_q;

endmodule

FILE: bench/tb_breakpoint_table_step_target_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_breakpoint_table_step_target_unit
// Self-checking bench for the breakpoint table and next-PC predictor. A
// scoreboard class mirrors the table, the register shadow and the two
// configuration registers, forms the expected result of every accepted
// command and checks result beats in order. Stimulus is a directed opening
// followed by random commands over a small address pool, under several
// ROM limits and break encodings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_breakpoint_table_step_target_unit;

	localparam int unsigned TABLE_DEPTH = 8;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned POOL_SIZE   = 12;
	// command code that the block must ignore
	localparam logic [2:0]  CMD_UNDEFINED = 3'd7;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] target;
		logic        plant;
		logic        restore;
		logic [31:0] restore_word;
		logic        run;
		logic        onbp;
	} bpt_result_t;

	// Mirror of the table, shadow and settings; holds outstanding results
	class bpt_scoreboard;
		logic [20:0] rom_start;
		logic [31:0] break_word;
		bit          ent_valid[TABLE_DEPTH];
		logic [19:0] ent_addr[TABLE_DEPTH];
		logic [31:0] ent_insn[TABLE_DEPTH];
		logic [31:0] shadow[16];
		bpt_result_t pending_q[$];
		int unsigned errors;
		int unsigned results_checked;
		int unsigned cmd_count[8];
		int unsigned bp_hits;
		int unsigned loop_backs;
		int unsigned rom_stops;

		function new();
			rom_start  = bpt_pkg::ROM_START_RST;
			break_word = bpt_pkg::BREAK_WORD_RST;
			foreach (ent_valid[i]) begin
				ent_valid[i] = 1'b0;
				ent_addr[i]  = '0;
				ent_insn[i]  = '0;
			end
			foreach (shadow[i]) shadow[i] = '0;
			errors = 0;
			results_checked = 0;
			foreach (cmd_count[i]) cmd_count[i] = 0;
			bp_hits = 0;
			loop_backs = 0;
			rom_stops = 0;
		endfunction

		function void write_config(logic [bpt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			if (idx == bpt_pkg::CFG_ROM_START)
				rom_start = data[20:0];
			else if (idx == bpt_pkg::CFG_BREAK_WORD)
				break_word = data;
		endfunction

		// next PC after insn at pc; step over runs through calls
		function logic [31:0] next_pc(logic [19:0] pc, logic [31:0] insn, bit into);
			logic [31:0] pc32;
			logic [31:0] nxt;
			logic [31:0] rs;
			logic [31:0] off;
			logic [3:0]  cls;
			pc32 = {12'd0, pc};
			nxt  = pc32 + 32'd1;
			cls  = insn[31:28];
			rs   = shadow[insn[23:20]];
			off  = {{12{insn[19]}}, insn[19:0]};
			case (cls) inside
				bpt_pkg::OP_J, bpt_pkg::OP_JAL: begin
					if (into || cls == bpt_pkg::OP_J)
						nxt = {12'd0, insn[19:0]};
				end
				bpt_pkg::OP_JR, bpt_pkg::OP_JALR: begin
					if (into || cls == bpt_pkg::OP_JR)
						nxt = rs;
				end
				bpt_pkg::OP_BEQZ: begin
					if (rs == 32'd0)
						nxt = pc32 + 32'd1 + off;
				end
				bpt_pkg::OP_BNEZ: begin
					if (rs != 32'd0)
						nxt = pc32 + 32'd1 + off;
				end
				default: ;
			endcase
			return nxt;
		endfunction

		// accepted command beat: update the mirror and queue its result
		function void note_command(logic [2:0] op, logic [19:0] pc, logic [31:0] word,
				logic [3:0] ridx, logic [31:0] rval);
			bpt_result_t res;
			int          hit;
			logic [31:0] insn;
			logic [31:0] pc32;
			logic [3:0]  cls;
			res  = '0;
			hit  = -1;
			pc32 = {12'd0, pc};
			cmd_count[op]++;
			case (op) inside
				bpt_pkg::CMD_CLEAR: begin
					foreach (ent_valid[i]) ent_valid[i] = 1'b0;
				end
				bpt_pkg::CMD_SET: begin
					res.target = pc32;
					res.status = bpt_pkg::ST_FULL;
					// first matching or free entry decides
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						if (ent_valid[i] && ent_addr[i] == pc) begin
							res.status = bpt_pkg::ST_ALREADY;
							break;
						end
						if (!ent_valid[i]) begin
							if ({1'b0, pc} >= rom_start) begin
								res.status = bpt_pkg::ST_ROM;
							end else begin
								ent_valid[i] = 1'b1;
								ent_addr[i]  = pc;
								ent_insn[i]  = word;
								res.plant    = 1'b1;
								res.status   = bpt_pkg::ST_OK;
							end
							break;
						end
					end
				end
				bpt_pkg::CMD_REMOVE: begin
					res.target = pc32;
					res.status = bpt_pkg::ST_NOT_FOUND;
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						if (ent_valid[i] && ent_addr[i] == pc) begin
							ent_valid[i]     = 1'b0;
							res.restore      = 1'b1;
							res.restore_word = ent_insn[i];
							res.status       = bpt_pkg::ST_OK;
							break;
						end
					end
				end
				bpt_pkg::CMD_STEP_INTO, bpt_pkg::CMD_STEP_OVER, bpt_pkg::CMD_CONTINUE: begin
					insn = word;
					if (word == break_word) begin
						for (int i = 0; i < TABLE_DEPTH; i++) begin
							if (ent_valid[i] && ent_addr[i] == pc) begin
								hit = i;
								break;
							end
						end
					end
					if (hit >= 0) begin
						res.onbp = 1'b1;
						insn = ent_insn[hit];
						bp_hits++;
					end
					if (op == bpt_pkg::CMD_CONTINUE && hit < 0) begin
						res.run = 1'b1;
					end else begin
						cls = insn[31:28];
						res.target = next_pc(pc, insn, op != bpt_pkg::CMD_STEP_OVER);
						if (res.target == pc32) begin
							// jump-and-link onto itself still links
							if (cls == bpt_pkg::OP_JAL || cls == bpt_pkg::OP_JALR)
								shadow[bpt_pkg::LINK_REG] = pc32 + 32'd1;
							res.status = bpt_pkg::ST_LOOP_BACK;
							res.run = (op == bpt_pkg::CMD_CONTINUE);
							loop_backs++;
						end else begin
							if (op != bpt_pkg::CMD_CONTINUE && hit >= 0) begin
								res.restore      = 1'b1;
								res.restore_word = insn;
							end
							if (res.target >= {11'd0, rom_start}) begin
								res.status = bpt_pkg::ST_ROM;
								rom_stops++;
							end else begin
								if (op == bpt_pkg::CMD_CONTINUE) begin
									res.restore      = 1'b1;
									res.restore_word = insn;
								end
								res.plant = 1'b1;
								res.run   = 1'b1;
							end
						end
					end
				end
				bpt_pkg::CMD_WRITE_REG: begin
					if (ridx == 4'd0)
						res.status = bpt_pkg::ST_REG_ZERO;
					else
						shadow[ridx] = rval;
				end
				default: ;
			endcase
			pending_q.push_back(res);
		endfunction

		task report(string what, logic [31:0] got_v, logic [31:0] want_v);
			errors++;
			$display("mismatch %0d at result %0d: %s got 0x%0h, want 0x%0h",
				errors, results_checked, what, got_v, want_v);
		endtask

		// accepted result beat: compare with the oldest outstanding one
		task check_result(bpt_result_t got);
			bpt_result_t want;
			if (pending_q.size() == 0) begin
				report("result beat with none outstanding", got.status, 32'd0);
			end else begin
				want = pending_q.pop_front();
				results_checked++;
				if (got.status != want.status)
					report("status", got.status, want.status);
				if (got.target != want.target)
					report("target_addr", got.target, want.target);
				if (got.plant != want.plant)
					report("plant_valid", got.plant, want.plant);
				if (got.restore != want.restore)
					report("restore_valid", got.restore, want.restore);
				if (got.restore_word != want.restore_word)
					report("restore_word", got.restore_word, want.restore_word);
				if (got.run != want.run)
					report("start_run", got.run, want.run);
				if (got.onbp != want.onbp)
					report("on_breakpoint", got.onbp, want.onbp);
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  opcode;
	logic [19:0] address;
	logic [31:0] mem_word;
	logic [3:0]  reg_index;
	logic [31:0] reg_value;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [31:0] target_addr;
	logic        plant_valid;
	logic        restore_valid;
	logic [31:0] restore_word;
	logic        start_run;
	logic        on_breakpoint;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [bpt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	bpt_scoreboard sb;
	bpt_result_t   seen_result;
	logic [19:0]   addr_pool[POOL_SIZE];
	logic [31:0]   cur_break_word;
	bit            quiet;
	int unsigned   cycle_count;

	breakpoint_table_step_target_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.address(address),
		.mem_word(mem_word),
		.reg_index(reg_index),
		.reg_value(reg_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.target_addr(target_addr),
		.plant_valid(plant_valid),
		.restore_valid(restore_valid),
		.restore_word(restore_word),
		.start_run(start_run),
		.on_breakpoint(on_breakpoint),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("CHECKS FAILED");
		$finish;
	end

	// Result-side back-pressure
	always @(posedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 8);
	end

	// Beat monitor: values read here are the ones present at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_config(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_command(opcode, address, mem_word, reg_index, reg_value);
			if (out_valid && out_ready) begin
				seen_result.status       = status;
				seen_result.target       = target_addr;
				seen_result.plant        = plant_valid;
				seen_result.restore      = restore_valid;
				seen_result.restore_word = restore_word;
				seen_result.run          = start_run;
				seen_result.onbp         = on_breakpoint;
				sb.check_result(seen_result);
			end
		end
	end

	// One command beat; valid stays up afterwards unless the next call idles
	task send_command(logic [2:0] op, logic [19:0] a, logic [31:0] w,
			logic [3:0] ri, logic [31:0] rv);
		while (!quiet && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		address   <= a;
		mem_word  <= w;
		reg_index <= ri;
		reg_value <= rv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task write_cfg(logic [bpt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Drop valid, let every outstanding result drain, then settle
	task wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (TABLE_DEPTH + 4) @(posedge clk);
	endtask

	task refresh_pool(logic [20:0] rom);
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (rom == 21'd0 || rom > 21'hfffff || i >= POOL_SIZE - 2)
				addr_pool[i] = 20'($urandom_range(32'hfffff));
			else
				addr_pool[i] = 20'($urandom_range(32'(rom - 21'd1)));
		end
	endtask

	function automatic logic [19:0] pick_addr();
		logic [19:0] a;
		if ($urandom_range(99) < 75)
			a = addr_pool[$urandom_range(POOL_SIZE - 1)];
		else
			a = 20'($urandom_range(32'hfffff));
		return a;
	endfunction

	// Mostly control-flow words, aimed at the pool or at the PC itself
	function automatic logic [31:0] random_insn(logic [19:0] pc);
		logic [3:0]  cls;
		logic [19:0] low;
		logic [31:0] r;
		int unsigned sel;
		r = $urandom;
		if ($urandom_range(99) < 12)
			return r;
		case ($urandom_range(5))
			0: cls = bpt_pkg::OP_J;
			1: cls = bpt_pkg::OP_JR;
			2: cls = bpt_pkg::OP_JAL;
			3: cls = bpt_pkg::OP_JALR;
			4: cls = bpt_pkg::OP_BEQZ;
			default: cls = bpt_pkg::OP_BNEZ;
		endcase
		sel = $urandom_range(99);
		if (sel < 20) begin
			low = (cls == bpt_pkg::OP_BEQZ || cls == bpt_pkg::OP_BNEZ) ? 20'hfffff : pc;
		end else if (sel < 50) begin
			low = addr_pool[$urandom_range(POOL_SIZE - 1)];
		end else if (sel < 75) begin
			low = 20'($urandom_range(31));
			if ($urandom_range(1) == 0)
				low = 20'hfffff - low;
		end else begin
			low = 20'($urandom_range(32'hfffff));
		end
		return {cls, r[27:20], low};
	endfunction

	function automatic logic [31:0] random_reg_value();
		logic [31:0] v;
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 40)
			v = {12'd0, addr_pool[$urandom_range(POOL_SIZE - 1)]};
		else if (sel < 60)
			v = 32'd0;
		else
			v = $urandom;
		return v;
	endfunction

	task random_command();
		logic [2:0]  op;
		logic [19:0] a;
		logic [31:0] w;
		logic [3:0]  ri;
		logic [31:0] rv;
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 3)       op = bpt_pkg::CMD_CLEAR;
		else if (sel < 28) op = bpt_pkg::CMD_SET;
		else if (sel < 40) op = bpt_pkg::CMD_REMOVE;
		else if (sel < 55) op = bpt_pkg::CMD_STEP_INTO;
		else if (sel < 67) op = bpt_pkg::CMD_STEP_OVER;
		else if (sel < 82) op = bpt_pkg::CMD_CONTINUE;
		else if (sel < 97) op = bpt_pkg::CMD_WRITE_REG;
		else               op = CMD_UNDEFINED;
		a  = pick_addr();
		w  = $urandom;
		ri = 4'($urandom_range(15));
		rv = $urandom;
		case (op) inside
			bpt_pkg::CMD_SET: w = random_insn(a);
			bpt_pkg::CMD_STEP_INTO, bpt_pkg::CMD_STEP_OVER, bpt_pkg::CMD_CONTINUE: begin
				if ($urandom_range(99) < 65)
					w = cur_break_word;
				else
					w = random_insn(a);
			end
			bpt_pkg::CMD_WRITE_REG: rv = random_reg_value();
			default: ;
		endcase
		send_command(op, a, w, ri, rv);
	endtask

	// New settings, then n random commands; the first quiet_n without idling
	task run_phase(int unsigned n, logic [20:0] rom, logic [31:0] bw, int unsigned quiet_n);
		wait_idle();
		write_cfg(bpt_pkg::CFG_ROM_START, {11'd0, rom});
		write_cfg(bpt_pkg::CFG_BREAK_WORD, bw);
		cfg_valid <= 1'b0;
		cur_break_word = bw;
		refresh_pool(rom);
		for (int unsigned i = 0; i < n; i++) begin
			quiet = (i < quiet_n);
			random_command();
		end
		quiet = 1'b0;
	endtask

	// Opening sequence at reset settings (ROM from 0x80000, break word 0)
	task run_directed();
		logic [19:0] a;
		send_command(bpt_pkg::CMD_WRITE_REG, 20'd0, 32'd0, 4'd0, 32'hffffffff);
		send_command(bpt_pkg::CMD_WRITE_REG, 20'hfffff, 32'hffffffff,
			bpt_pkg::LINK_REG, 32'hffffffff);
		send_command(bpt_pkg::CMD_WRITE_REG, 20'd0, 32'd0, 4'd2, 32'd5);
		send_command(bpt_pkg::CMD_SET, 20'h00000, {bpt_pkg::OP_J, 8'h00, 20'h00010},
			4'hf, 32'd0);
		send_command(bpt_pkg::CMD_SET, 20'h00000, 32'hffffffff, 4'd0, 32'd0);
		send_command(bpt_pkg::CMD_SET, 20'h7ffff, {bpt_pkg::OP_JAL, 8'h00, 20'h7ffff},
			4'd0, 32'd0);
		// address lies in ROM, so the first free entry is not taken
		send_command(bpt_pkg::CMD_SET, 20'h80000, 32'd0, 4'd0, 32'd0);
		send_command(bpt_pkg::CMD_STEP_INTO, 20'h00000, 32'd0, 4'd0, 32'd0);
		// jal onto itself: links and runs in place
		send_command(bpt_pkg::CMD_CONTINUE, 20'h7ffff, 32'd0, 4'd0, 32'd0);
		// step over the call lands in ROM, restore still reported
		send_command(bpt_pkg::CMD_STEP_OVER, 20'h7ffff, 32'd0, 4'd0, 32'd0);
		send_command(bpt_pkg::CMD_CONTINUE, 20'h00123, 32'h12345678, 4'd0, 32'd0);
		send_command(bpt_pkg::CMD_SET, 20'h00005,
			{bpt_pkg::OP_JR, 4'h0, bpt_pkg::LINK_REG, 20'h00000}, 4'd0, 32'd0);
		// continue whose target is in ROM does nothing
		send_command(bpt_pkg::CMD_CONTINUE, 20'h00005, 32'd0, 4'd0, 32'd0);
		send_command(bpt_pkg::CMD_STEP_INTO, 20'h00200,
			{bpt_pkg::OP_BEQZ, 4'h0, 4'h1, 20'hfffff}, 4'd0, 32'd0);
		send_command(bpt_pkg::CMD_STEP_INTO, 20'h00100,
			{bpt_pkg::OP_BNEZ, 4'h0, 4'h2, 20'h7ffff}, 4'd0, 32'd0);
		// most negative offset wraps below zero
		send_command(bpt_pkg::CMD_STEP_OVER, 20'h00000,
			{bpt_pkg::OP_BNEZ, 4'h0, 4'h2, 20'h80000}, 4'd0, 32'd0);
		send_command(bpt_pkg::CMD_STEP_INTO, 20'h00010,
			{bpt_pkg::OP_JALR, 4'h0, 4'h1, 20'h00000}, 4'd0, 32'd0);
		send_command(bpt_pkg::CMD_REMOVE, 20'h00000, 32'd0, 4'd0, 32'd0);
		send_command(bpt_pkg::CMD_REMOVE, 20'h00000, 32'd0, 4'd0, 32'd0);
		// fill the rest of the table, then one more
		for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
			a = 20'h00300 + 20'(i);
			send_command(bpt_pkg::CMD_SET, a, ~{bpt_pkg::OP_J, 8'h00, a}, 4'd0, 32'd0);
		end
		send_command(CMD_UNDEFINED, 20'hfffff, 32'hffffffff, 4'hf, 32'hffffffff);
		send_command(bpt_pkg::CMD_CLEAR, 20'h00000, 32'd0, 4'd0, 32'd0);
		// break word at the PC but no entry records it
		send_command(bpt_pkg::CMD_STEP_INTO, 20'h00400, 32'd0, 4'd0, 32'd0);
	endtask

	// Main sequence
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		opcode         = bpt_pkg::CMD_CLEAR;
		address        = '0;
		mem_word       = '0;
		reg_index      = '0;
		reg_value      = '0;
		out_ready      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = bpt_pkg::CFG_ROM_START;
		cfg_data       = '0;
		quiet          = 1'b0;
		cur_break_word = bpt_pkg::BREAK_WORD_RST;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_phase(320, 21'h40000, $urandom, 0);
		run_phase(100, 21'h00000, 32'h00000000, 0);
		run_phase(330, 21'h100000, 32'hffffffff, 200);
		run_phase(300, bpt_pkg::ROM_START_RST, $urandom, 0);
		wait_idle();

		$display("commands: %0d set, %0d remove, %0d step, %0d continue, %0d write, %0d clear",
			sb.cmd_count[bpt_pkg::CMD_SET], sb.cmd_count[bpt_pkg::CMD_REMOVE],
			sb.cmd_count[bpt_pkg::CMD_STEP_INTO] + sb.cmd_count[bpt_pkg::CMD_STEP_OVER],
			sb.cmd_count[bpt_pkg::CMD_CONTINUE], sb.cmd_count[bpt_pkg::CMD_WRITE_REG],
			sb.cmd_count[bpt_pkg::CMD_CLEAR]);
		$display("%0d results, %0d on breakpoint, %0d loop backs, %0d ROM stops, %0d mismatches",
			sb.results_checked, sb.bp_hits, sb.loop_backs, sb.rom_stops, sb.errors);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: breakpoint_table_step_target_unit.f
src/bpt_pkg.sv
src/bpt_predict.sv
src/breakpoint_table_step_target_unit.sv
bench/tb_breakpoint_table_step_target_unit.sv
